[hdl/smta_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package smta_pkg;

    typedef struct packed {
        logic load_in;
        logic fill_step;
        logic slide_remove;
        logic slide_insert;
        logic load_out;
    } smta_cmd_t;

    typedef struct packed {
        logic filling;
    } smta_stat_t;

    localparam logic [6:0] WINDOW_SIZE_RESET = 7'd64;

endpackage

`default_nettype wire

[hdl/smta_control.sv]
`timescale 1ns / 1ps
`default_nettype none

module smta_control (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire smta_pkg::smta_stat_t stat,
    output smta_pkg::smta_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_INSERT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.filling)
                begin
                    cmd.fill_step = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.slide_remove = 1'b1;
                    state_next       = S_INSERT;
                end
            end
            S_INSERT:
            begin
                cmd.slide_insert = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[hdl/smta_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module smta_datapath #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [6:0]             window_size,
    input  wire logic [SAMPLE_BITS-1:0] amount,
    input  wire smta_pkg::smta_cmd_t    cmd,
    output smta_pkg::smta_stat_t        stat,
    output logic                        window_ready,
    output logic                        alert,
    output logic [SAMPLE_BITS:0]        twice_median,
    output logic [31:0]                 alert_total
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    logic [6:0]             win_size_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic [IDX_W-1:0]       ptr_reg;
    logic [31:0]            count_reg;
    logic [SAMPLE_BITS-1:0] amount_reg;
    logic [SAMPLE_BITS-1:0] oldest_reg;
    logic [SAMPLE_BITS:0]   twice_reg;
    logic                   ready_reg;
    logic                   alert_reg;
    logic                   out_ready_reg;
    logic                   out_alert_reg;
    logic [SAMPLE_BITS:0]   out_twice_reg;
    logic [31:0]            out_total_reg;

    logic [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_reg [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_next [WINDOW_MAX];

    logic [CNT_W-1:0]       eff_w;
    logic [CNT_W-1:0]       ins_cnt;
    logic [CNT_W-1:0]       ptr_plus;
    logic [IDX_W-1:0]       ptr_adv;
    logic [IDX_W-1:0]       mid_hi;
    logic [IDX_W-1:0]       mid_lo;
    logic [SAMPLE_BITS-1:0] sel_hi;
    logic [SAMPLE_BITS-1:0] sel_lo;
    logic [WINDOW_MAX-1:0]  lower_gt;
    logic [WINDOW_MAX-1:0]  self_gt;
    logic                   hit;
    logic                   ring_we;

    always_comb
    begin
        if (win_size_reg == 7'd0)
            eff_w = CNT_W'(1);
        else if (int'(win_size_reg) > WINDOW_MAX)
            eff_w = CNT_W'(WINDOW_MAX);
        else
            eff_w = CNT_W'(win_size_reg);
    end

    assign stat.filling = (fill_reg < eff_w);
    assign ins_cnt      = cmd.fill_step ? fill_reg : (eff_w - CNT_W'(1));
    assign ring_we      = cmd.fill_step || cmd.slide_insert;
    assign ptr_plus     = CNT_W'(ptr_reg) + CNT_W'(1);
    assign ptr_adv      = (ptr_plus >= eff_w) ? '0 : ptr_plus[IDX_W-1:0];
    assign hit          = ({1'b0, amount_reg} >= twice_reg);

    assign mid_hi = IDX_W'(eff_w >> 1);
    assign mid_lo = eff_w[0] ? mid_hi : (mid_hi - IDX_W'(1));

    always_comb
    begin
        sel_hi = '0;
        sel_lo = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            sel_hi = sel_hi | (cell_reg[i] & {SAMPLE_BITS{mid_hi == IDX_W'(i)}});
            sel_lo = sel_lo | (cell_reg[i] & {SAMPLE_BITS{mid_lo == IDX_W'(i)}});
        end
    end

    always_comb
    begin
        lower_gt[0] = 1'b0;
        for (int i = 1; i < WINDOW_MAX; i++)
            lower_gt[i] = (CNT_W'(i - 1) < ins_cnt) && (cell_reg[i-1] > amount_reg);
        for (int i = 0; i < WINDOW_MAX; i++)
            self_gt[i] = (CNT_W'(i) < ins_cnt) && (cell_reg[i] > amount_reg);
    end

    always_comb
    begin
        cell_next = cell_reg;
        if (cmd.slide_remove)
        begin
            for (int i = 0; i < WINDOW_MAX - 1; i++)
            begin
                if ((CNT_W'(i + 1) < eff_w) && (cell_reg[i] >= oldest_reg))
                    cell_next[i] = cell_reg[i+1];
            end
        end
        else if (ring_we)
        begin
            cell_next[0] = (self_gt[0] || (ins_cnt == '0)) ? amount_reg : cell_reg[0];
            for (int i = 1; i < WINDOW_MAX; i++)
            begin
                if (lower_gt[i])
                    cell_next[i] = cell_reg[i-1];
                else if (self_gt[i] || (CNT_W'(i) == ins_cnt))
                    cell_next[i] = amount_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        if (ring_we)
            ring[ptr_reg] <= amount_reg;
        if (cmd.load_in)
        begin
            oldest_reg <= ring[ptr_reg];
            amount_reg <= amount;
        end
        if (cmd.fill_step)
        begin
            twice_reg <= '0;
            ready_reg <= 1'b0;
            alert_reg <= 1'b0;
        end
        if (cmd.slide_remove)
            twice_reg <= {1'b0, sel_lo} + {1'b0, sel_hi};
        if (cmd.slide_insert)
        begin
            ready_reg <= 1'b1;
            alert_reg <= hit;
        end
        if (cmd.load_out)
        begin
            out_ready_reg <= ready_reg;
            out_alert_reg <= alert_reg;
            out_twice_reg <= twice_reg;
            out_total_reg <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg <= smta_pkg::WINDOW_SIZE_RESET;
            fill_reg     <= '0;
            ptr_reg      <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                win_size_reg <= window_size;
                fill_reg     <= '0;
                ptr_reg      <= '0;
            end
            else
            begin
                if (cmd.fill_step)
                    fill_reg <= fill_reg + CNT_W'(1);
                if (ring_we)
                    ptr_reg <= ptr_adv;
            end
            if (cmd.slide_insert && hit && (count_reg != '1))
                count_reg <= count_reg + 32'd1;
        end
    end

    assign window_ready = out_ready_reg;
    assign alert        = out_alert_reg;
    assign twice_median = out_twice_reg;
    assign alert_total  = out_total_reg;

endmodule

`default_nettype wire

[hdl/sliding_median_threshold_alert_unit.sv]
// Sliding median threshold alert.
// Input channel: in_valid / in_stall with the sample on amount. Output channel:
// out_valid / out_stall with window_ready, alert, twice_median and alert_total.
// A transfer happens at a rising edge with valid high and stall low.
// Configuration: cfg_write with window_size sets the window length and restarts
// the fill; write it only while the block is idle. The alert total is kept.
// One item is worked at a time: the sequencer steps through ring read, median sum
// and removal, then insertion into the row of sorted compare-and-shift cells; while
// the window fills, the median sum and removal step is skipped. The result is
// registered when the sequence ends.
// The result sits in an output register; the next item is taken while it waits,
// and its result is held back until the waiting result has been transferred.
// Reset: window length 64, empty window, alert total zero, no result pending.
// While the receiver stalls, the shown result holds and the block stops after
// finishing the next item.
`timescale 1ns / 1ps
`default_nettype none

module sliding_median_threshold_alert_unit #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [6:0]             window_size,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [SAMPLE_BITS-1:0] amount,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        window_ready,
    output logic                        alert,
    output logic [SAMPLE_BITS:0]        twice_median,
    output logic [31:0]                 alert_total
);

    smta_pkg::smta_cmd_t  cmd;
    smta_pkg::smta_stat_t stat;

    smta_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    smta_datapath #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .window_size  (window_size),
        .amount       (amount),
        .cmd          (cmd),
        .stat         (stat),
        .window_ready (window_ready),
        .alert        (alert),
        .twice_median (twice_median),
        .alert_total  (alert_total)
    );

    a_load_then_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> (cmd.fill_step || cmd.slide_remove))
        else $error("accepted item not followed by an update step");

    a_insert_after_remove: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.slide_insert |-> $past(cmd.slide_remove))
        else $error("insertion without preceding removal");

    a_load_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("loaded result not presented");

    a_fill_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !window_ready) |-> (!alert && (twice_median == '0)))
        else $error("filling result carries a test value");

endmodule

`default_nettype wire

[tb/tb_sliding_median_threshold_alert_unit.sv]
`timescale 1ns / 1ps

module tb_sliding_median_threshold_alert_unit;

    localparam int WINDOW_MAX  = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 85;
    localparam int ROWS        = 29;

    typedef struct packed {
        logic        ready;
        logic        alert;
        logic [16:0] twice;
        logic [31:0] total;
    } alert_result_t;

    typedef struct packed {
        logic          is_cfg;
        logic [6:0]    cfg_val;
        logic [15:0]   sample;
        logic          typed;
        alert_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [6:0]  window_size = 7'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] amount = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        window_ready;
    logic        alert;
    logic [16:0] twice_median;
    logic [31:0] alert_total;

    logic [15:0]   win_sorted [WINDOW_MAX];
    logic [15:0]   win_ring [WINDOW_MAX];
    int            ring_slot = 0;
    int            held_count = 0;
    logic [31:0]   alerts_so_far = '0;
    logic [6:0]    win_setting = smta_pkg::WINDOW_SIZE_RESET;

    alert_result_t pending [$];
    alert_result_t want_res;
    int            mismatches = 0;
    int            samples_sent = 0;
    int            results_seen = 0;
    int            full_results = 0;
    int            alerts_seen = 0;
    int            settings_used = 1;
    int            cycle_count = 0;
    int            rx_wait = 0;
    int            hold_left = 0;
    bit            hold_request = 1'b0;
    bit            steady = 1'b0;

    stim_row_t directed_rows [ROWS] = '{
        '{1'b0, 7'd0,   16'hFFFF, 1'b1, '{1'b0, 1'b0, 17'd0,      32'd0}},
        '{1'b0, 7'd0,   16'h0000, 1'b1, '{1'b0, 1'b0, 17'd0,      32'd0}},
        '{1'b1, 7'd0,   16'h0000, 1'b0, '0},
        '{1'b0, 7'd0,   16'd5,    1'b1, '{1'b0, 1'b0, 17'd0,      32'd0}},
        '{1'b0, 7'd0,   16'd10,   1'b1, '{1'b1, 1'b1, 17'd10,     32'd1}},
        '{1'b0, 7'd0,   16'd0,    1'b1, '{1'b1, 1'b0, 17'd20,     32'd1}},
        '{1'b0, 7'd0,   16'd0,    1'b1, '{1'b1, 1'b1, 17'd0,      32'd2}},
        '{1'b1, 7'd1,   16'h0000, 1'b0, '0},
        '{1'b0, 7'd0,   16'hFFFF, 1'b1, '{1'b0, 1'b0, 17'd0,      32'd2}},
        '{1'b0, 7'd0,   16'hFFFF, 1'b1, '{1'b1, 1'b0, 17'd131070, 32'd2}},
        '{1'b0, 7'd0,   16'hFFFF, 1'b1, '{1'b1, 1'b0, 17'd131070, 32'd2}},
        '{1'b1, 7'd2,   16'h0000, 1'b0, '0},
        '{1'b0, 7'd0,   16'd7,    1'b1, '{1'b0, 1'b0, 17'd0,      32'd2}},
        '{1'b0, 7'd0,   16'd7,    1'b1, '{1'b0, 1'b0, 17'd0,      32'd2}},
        '{1'b0, 7'd0,   16'd14,   1'b1, '{1'b1, 1'b1, 17'd14,     32'd3}},
        '{1'b0, 7'd0,   16'd13,   1'b1, '{1'b1, 1'b0, 17'd21,     32'd3}},
        '{1'b1, 7'd3,   16'h0000, 1'b0, '0},
        '{1'b0, 7'd0,   16'd4,    1'b1, '{1'b0, 1'b0, 17'd0,      32'd3}},
        '{1'b0, 7'd0,   16'd4,    1'b1, '{1'b0, 1'b0, 17'd0,      32'd3}},
        '{1'b0, 7'd0,   16'd4,    1'b1, '{1'b0, 1'b0, 17'd0,      32'd3}},
        '{1'b0, 7'd0,   16'd4,    1'b1, '{1'b1, 1'b0, 17'd8,      32'd3}},
        '{1'b0, 7'd0,   16'd8,    1'b1, '{1'b1, 1'b1, 17'd8,      32'd4}},
        '{1'b0, 7'd0,   16'd0,    1'b0, '0},
        '{1'b1, 7'd127, 16'h0000, 1'b0, '0},
        '{1'b0, 7'd0,   16'h8000, 1'b0, '0},
        '{1'b0, 7'd0,   16'h7FFF, 1'b0, '0},
        '{1'b0, 7'd0,   16'h5555, 1'b0, '0},
        '{1'b1, 7'd65,  16'h0000, 1'b0, '0},
        '{1'b0, 7'd0,   16'hAAAA, 1'b0, '0}
    };

    sliding_median_threshold_alert_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .window_size  (window_size),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .amount       (amount),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .window_ready (window_ready),
        .alert        (alert),
        .twice_median (twice_median),
        .alert_total  (alert_total)
    );

    always #5 clk = ~clk;

    function automatic void sorted_put(input int count, input logic [15:0] v);
        int pos;
        pos = 0;
        while (pos < count && win_sorted[pos] <= v)
            pos++;
        for (int i = count; i > pos; i--)
            win_sorted[i] = win_sorted[i-1];
        win_sorted[pos] = v;
    endfunction

    function automatic alert_result_t median_step(input logic [15:0] a);
        alert_result_t r;
        int            w;
        int            slot;
        int            pos;
        int            mid;
        r = '0;
        w = (win_setting == 7'd0) ? 1 : ((win_setting > WINDOW_MAX) ? WINDOW_MAX : win_setting);
        slot = ring_slot % w;
        if (held_count < w)
        begin
            sorted_put(held_count, a);
            win_ring[slot] = a;
            held_count++;
        end
        else
        begin
            mid = w / 2;
            if (w % 2 != 0)
                r.twice = {win_sorted[mid], 1'b0};
            else
                r.twice = {1'b0, win_sorted[mid-1]} + {1'b0, win_sorted[mid]};
            r.ready = 1'b1;
            if ({1'b0, a} >= r.twice)
            begin
                r.alert = 1'b1;
                if (alerts_so_far != '1)
                    alerts_so_far++;
            end
            // drop the oldest sample: first equal entry, else the last one
            pos = 0;
            while (pos < w && win_sorted[pos] != win_ring[slot])
                pos++;
            if (pos >= w)
                pos = w - 1;
            for (int i = pos; i < w - 1; i++)
                win_sorted[i] = win_sorted[i+1];
            sorted_put(w - 1, a);
            win_ring[slot] = a;
        end
        slot++;
        if (slot >= w)
            slot = 0;
        ring_slot = slot;
        r.total = alerts_so_far;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_window(input logic [6:0] v);
        cfg_write <= 1'b1;
        window_size <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        win_setting = v;
        held_count = 0;
        ring_slot = 0;
        settings_used++;
    endtask

    task automatic put_sample(input logic [15:0] a, input int gap, input bit typed,
                              input alert_result_t want);
        alert_result_t pred;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        amount <= a;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = median_step(a);
        pending.insert(pending.size(), typed ? want : pred);
        samples_sent++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_count,
                     pending.size());
            $display("Verification failed");
            $finish;
        end
    end

    // check each result transfer, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending.size() == 0)
                begin
                    report_mismatch("result transfer with nothing pending");
                end
                else
                begin
                    want_res = pending.pop_front();
                    if (window_ready !== want_res.ready)
                        report_mismatch($sformatf("window_ready got %0b want %0b",
                                        window_ready, want_res.ready));
                    if (alert !== want_res.alert)
                        report_mismatch($sformatf("alert got %0b want %0b",
                                        alert, want_res.alert));
                    if (twice_median !== want_res.twice)
                        report_mismatch($sformatf("twice_median got %0d want %0d",
                                        twice_median, want_res.twice));
                    if (alert_total !== want_res.total)
                        report_mismatch($sformatf("alert_total got %0d want %0d",
                                        alert_total, want_res.total));
                end
                if (window_ready === 1'b1)
                    full_results++;
                if (alert === 1'b1)
                    alerts_seen++;
                rx_wait = steady ? 0 : $urandom_range(0, 15);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        logic [6:0]  setting;
        logic [15:0] a;
        int          gap;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            win_sorted[i] = '0;
            win_ring[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < ROWS; r++)
        begin
            if (directed_rows[r].is_cfg)
            begin
                wait_idle();
                write_window(directed_rows[r].cfg_val);
            end
            else
            begin
                put_sample(directed_rows[r].sample, $urandom_range(0, 3),
                           directed_rows[r].typed, directed_rows[r].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: setting = 7'd64;
                1: setting = 7'd1;
                2: setting = 7'd2;
                3: setting = 7'd127;
                4: setting = 7'd0;
                5: setting = 7'd3;
                6: setting = 7'($urandom_range(4, 63));
                default: setting = 7'($urandom_range(65, 126));
            endcase
            wait_idle();
            write_window(setting);
            steady = (ph % 3 == 0);
            // hold the output while the sender keeps offering
            if (ph == 0)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 5 && n == 40)
                    wait_idle();
                case ($urandom_range(0, 3))
                    0: a = 16'($urandom);
                    1: a = 16'($urandom_range(0, 7));
                    2: a = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'(1 << $urandom_range(0, 15));
                    default: a = 16'($urandom_range(0, 255));
                endcase
                gap = steady ? 0 : $urandom_range(0, 15);
                put_sample(a, gap, 1'b0, '0);
            end
        end

        wait_idle();
        steady = 1'b0;
        $display("Covered %0d samples over %0d window settings: %0d results, %0d with a full",
                 samples_sent, settings_used, results_seen, full_results);
        $display("window, %0d alerts, with random and long output stalls and input gaps.",
                 alerts_seen);
        if (mismatches == 0 && pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
